// ----- hdl/bmrc_pkg.sv -----
// shared types and constants of the bitmap rectangle cover block
`default_nettype none
package bmrc_pkg;

    // widest grid side the fixed field widths allow
    localparam int MAX_SIDE    = 8;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RIGHT,
        S_DOWN,
        S_MARK,
        S_FLUSH
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/bitmap_rectangle_cover.sv -----
// Covers the occupied cells of a square occupancy bitmap with rectangles in a greedy row-major
// scan. One 64-bit bitmap word is taken while s_tready is high; the block then works on it
// alone and returns one word per rectangle in scan order, tlast on the final one, at most 32
// rectangles; an empty area gives a single word with tuser low. All work runs through one row
// fetch and compare unit under a small sequencer: the scan visits cells one by one, and each
// rectangle adds right steps, down steps, one row clear per row and one rescan; a flush puts out
// the last word. A checkerboard of single cells takes longer than one full rectangle, as every
// rectangle adds its own right, down and clear steps. Words wait in an output register while
// the scan goes on; the sequencer stalls only when a second word is ready before the first was
// taken. The cfg registers must be written over the cfg port only while idle; the block itself
// does not enforce this.
`default_nettype none
module bitmap_rectangle_cover #(
    parameter int GRID_SIDE = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // cfg write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [3:0]  i_cfg_data,
    // bitmap input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // cell_mask[63:0]
    // rectangle output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // rect_x[2:0], rect_y[5:3], rect_width[9:6],
                                        // rect_height[13:10], zero[15:14]
    output logic [0:0]       m_tuser,   // rect_valid[0]
    output logic             m_tlast    // last_rect
);

    localparam int                 NCELL = GRID_SIDE * GRID_SIDE;
    localparam logic [3:0]         SIDE  = 4'(GRID_SIDE);
    localparam logic [bmrc_pkg::CNT_W-1:0] CNT_MAX = bmrc_pkg::CNT_W'(bmrc_pkg::MAX_RESULTS);

    bmrc_pkg::t_state r_state, n_state;

    logic [3:0]  r_cfg_w, r_cfg_h;
    logic [63:0] r_live, n_live;
    logic [2:0]  r_x, n_x, r_y, n_y;
    logic [2:0]  r_rx, n_rx, r_ry, n_ry;
    logic [3:0]  r_rw, n_rw, r_rh, n_rh;
    logic [3:0]  r_cy, n_cy;
    logic [bmrc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic        r_have_pend, n_have_pend;
    logic [2:0]  r_px, n_px, r_py, n_py;
    logic [3:0]  r_pw, n_pw, r_ph, n_ph;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_ox, n_ox, r_oy, n_oy;
    logic [3:0]  r_ow, n_ow, r_oh, n_oh;
    logic        r_ov, n_ov, r_ol, n_ol;

    logic [3:0]  w_eff, h_eff;
    logic [63:0] region, clr_mask;
    logic [3:0]  sel_row;
    logic [bmrc_pkg::MAX_SIDE-1:0] row_bits, span;
    logic [15:0] span_wide;
    logic [3:0]  col;
    logic        out_free;

    assign w_eff = (r_cfg_w > SIDE) ? SIDE : r_cfg_w;
    assign h_eff = (r_cfg_h > SIDE) ? SIDE : r_cfg_h;

    // cells inside the area in use
    always_comb begin
        region = '0;
        for (int b = 0; b < NCELL; b++) begin
            region[b] = (4'(b % GRID_SIDE) < w_eff) && (4'(b / GRID_SIDE) < h_eff);
        end
    end

    // shared row fetch: one row of the live map, selected per state
    always_comb begin
        case (r_state)
            bmrc_pkg::S_SCAN:  sel_row = {1'b0, r_y};
            bmrc_pkg::S_RIGHT: sel_row = {1'b0, r_ry};
            default:           sel_row = r_cy;
        endcase
        row_bits = '0;
        for (int k = 0; k < GRID_SIDE; k++) begin
            for (int i = 0; i < GRID_SIDE; i++) begin
                if (sel_row == 4'(k)) begin
                    row_bits[i] = r_live[k * GRID_SIDE + i];
                end
            end
        end
    end

    assign span_wide = ((16'd1 << r_rw) - 16'd1) << r_rx;
    assign span      = span_wide[bmrc_pkg::MAX_SIDE-1:0];
    assign col       = {1'b0, r_rx} + r_rw;

    always_comb begin
        clr_mask = '0;
        for (int b = 0; b < NCELL; b++) begin
            clr_mask[b] = (r_cy == 4'(b / GRID_SIDE)) && span[b % GRID_SIDE];
        end
    end

    assign out_free = !r_out_valid || m_tready;

    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_x         = r_x;
        n_y         = r_y;
        n_rx        = r_rx;
        n_ry        = r_ry;
        n_rw        = r_rw;
        n_rh        = r_rh;
        n_cy        = r_cy;
        n_cnt       = r_cnt;
        n_have_pend = r_have_pend;
        n_px        = r_px;
        n_py        = r_py;
        n_pw        = r_pw;
        n_ph        = r_ph;
        n_out_valid = r_out_valid && !m_tready;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_ow        = r_ow;
        n_oh        = r_oh;
        n_ov        = r_ov;
        n_ol        = r_ol;
        s_tready    = 1'b0;

        case (r_state)
            bmrc_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_live      = s_tdata & region;
                    n_x         = '0;
                    n_y         = '0;
                    n_cnt       = '0;
                    n_have_pend = 1'b0;
                    if (w_eff == 4'd0 || h_eff == 4'd0) begin
                        n_state = bmrc_pkg::S_FLUSH;
                    end else begin
                        n_state = bmrc_pkg::S_SCAN;
                    end
                end
            end
            bmrc_pkg::S_SCAN: begin
                if (row_bits[r_x]) begin
                    if (r_have_pend) begin
                        // next rectangle found: the pending one is not the last,
                        // unless the result limit is reached
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_ox        = r_px;
                            n_oy        = r_py;
                            n_ow        = r_pw;
                            n_oh        = r_ph;
                            n_ov        = 1'b1;
                            n_ol        = (r_cnt == CNT_MAX);
                            n_have_pend = 1'b0;
                            if (r_cnt == CNT_MAX) begin
                                n_state = bmrc_pkg::S_IDLE;
                            end else begin
                                n_state = bmrc_pkg::S_RIGHT;
                                n_rx    = r_x;
                                n_ry    = r_y;
                                n_rw    = 4'd1;
                            end
                        end
                    end else begin
                        n_state = bmrc_pkg::S_RIGHT;
                        n_rx    = r_x;
                        n_ry    = r_y;
                        n_rw    = 4'd1;
                    end
                end else if (({1'b0, r_x} + 4'd1) == w_eff) begin
                    n_x = '0;
                    if (({1'b0, r_y} + 4'd1) == h_eff) begin
                        n_state = bmrc_pkg::S_FLUSH;
                    end else begin
                        n_y = r_y + 3'd1;
                    end
                end else begin
                    n_x = r_x + 3'd1;
                end
            end
            bmrc_pkg::S_RIGHT: begin
                if (col < w_eff && row_bits[col[2:0]]) begin
                    n_rw = r_rw + 4'd1;
                end else begin
                    n_state = bmrc_pkg::S_DOWN;
                    n_cy    = {1'b0, r_ry} + 4'd1;
                    n_rh    = 4'd1;
                end
            end
            bmrc_pkg::S_DOWN: begin
                if (r_cy < h_eff && (row_bits & span) == span) begin
                    n_rh = r_rh + 4'd1;
                    n_cy = r_cy + 4'd1;
                end else begin
                    n_state = bmrc_pkg::S_MARK;
                    n_cy    = {1'b0, r_ry};
                end
            end
            bmrc_pkg::S_MARK: begin
                n_live = r_live & ~clr_mask;
                if (r_cy == ({1'b0, r_ry} + r_rh - 4'd1)) begin
                    n_state     = bmrc_pkg::S_SCAN;
                    n_have_pend = 1'b1;
                    n_px        = r_rx;
                    n_py        = r_ry;
                    n_pw        = r_rw;
                    n_ph        = r_rh;
                    n_cnt       = r_cnt + bmrc_pkg::CNT_W'(1);
                end else begin
                    n_cy = r_cy + 4'd1;
                end
            end
            bmrc_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_ol        = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = bmrc_pkg::S_IDLE;
                    if (r_have_pend) begin
                        n_ox = r_px;
                        n_oy = r_py;
                        n_ow = r_pw;
                        n_oh = r_ph;
                        n_ov = 1'b1;
                    end else begin
                        n_ox = '0;
                        n_oy = '0;
                        n_ow = '0;
                        n_oh = '0;
                        n_ov = 1'b0;
                    end
                end
            end
            default: begin
                n_state = bmrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmrc_pkg::S_IDLE;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_cfg_w     <= 4'd8;
            r_cfg_h     <= 4'd8;
        end else begin
            r_state     <= n_state;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg_we && i_cfg_idx == bmrc_pkg::REG_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == bmrc_pkg::REG_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_live <= n_live;
        r_x    <= n_x;
        r_y    <= n_y;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_rw   <= n_rw;
        r_rh   <= n_rh;
        r_cy   <= n_cy;
        r_px   <= n_px;
        r_py   <= n_py;
        r_pw   <= n_pw;
        r_ph   <= n_ph;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_ow   <= n_ow;
        r_oh   <= n_oh;
        r_ov   <= n_ov;
        r_ol   <= n_ol;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_oh, r_ow, r_oy, r_ox};
    assign m_tuser  = r_ov;
    assign m_tlast  = r_ol;

    // rectangle count never passes the result limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("rectangle count beyond limit");

    // a rectangle being grown or cleared stays inside the used columns
    a_rect_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmrc_pkg::S_DOWN || r_state == bmrc_pkg::S_MARK)
        |-> (r_rw != 4'd0 && col <= w_eff))
        else $error("rectangle outside used columns");

    // no live cell outside the area in use while a bitmap is worked on
    a_live_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bmrc_pkg::S_IDLE) |-> ((r_live & ~region) == 64'd0))
        else $error("live cell outside area");

    // the flush puts out a final word and ends the bitmap
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmrc_pkg::S_FLUSH && out_free)
        |=> (r_out_valid && r_ol && r_state == bmrc_pkg::S_IDLE && !r_have_pend))
        else $error("flush did not end bitmap");

    // a word with the empty marking is always the final one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ov) |-> (r_ol && r_ow == 4'd0 && r_oh == 4'd0))
        else $error("empty result not final");

endmodule
`default_nettype wire
